// ===== rtl/button_debounce_multimode_defines.svh =====
// Assertion macros shared by the button debouncer RTL.
// Both macros assume a clock named clk and an active-low reset named arst_n.
`ifndef BUTTON_DEBOUNCE_MULTIMODE_DEFINES_SVH
`define BUTTON_DEBOUNCE_MULTIMODE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BDM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bdm assertion failed");
`define BDM_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("bdm forbidden condition seen");
`else
`define BDM_ASSERT(lbl, prop)
`define BDM_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/bdm_pkg.sv =====
// ----------------------------------------------------------------------------
// bdm_pkg
// Types, register map and helpers for the multimode button debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package bdm_pkg;

	localparam int TIME_BITS = 32;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	typedef logic [TIME_BITS-1:0] tstamp_t;

	typedef enum logic [1:0] {
		MODE_TOGGLE = 2'd0,
		MODE_HOLD   = 2'd1,
		MODE_PULSE  = 2'd2,
		MODE_REPEAT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE     = 2'd0,
		REG_DEBOUNCE = 2'd1,
		REG_REPEAT   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] debounce_ms;
		logic [15:0] repeat_interval_ms;
	} cfg_t;

	localparam mode_t       MODE_RST     = MODE_PULSE;
	localparam logic [15:0] DEBOUNCE_RST = 16'd20;
	localparam logic [15:0] REPEAT_RST   = 16'd500;

	// bring the 32-bit port timestamp to the internal time width
	function automatic tstamp_t to_tstamp(input logic [31:0] t);
		return TIME_BITS'(t);
	endfunction

	function automatic tstamp_t ms16_to_tstamp(input logic [15:0] v);
		return TIME_BITS'(v);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bdm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bdm_cfg_regs
// APB register file: mode, debounce time and repeat interval.
// ----------------------------------------------------------------------------
`default_nettype none

module bdm_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bdm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bdm_pkg::DATA_W-1:0]   pwdata,
	output logic      [bdm_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output bdm_pkg::cfg_t                     cfg
);

	logic              wr_en;
	bdm_pkg::reg_idx_t idx;
	bdm_pkg::cfg_t     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = bdm_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode               <= bdm_pkg::MODE_RST;
			cfg_q.debounce_ms        <= bdm_pkg::DEBOUNCE_RST;
			cfg_q.repeat_interval_ms <= bdm_pkg::REPEAT_RST;
		end else if (wr_en) begin
			case (idx)
				bdm_pkg::REG_MODE: begin
					cfg_q.mode <= bdm_pkg::mode_t'(pwdata[1:0]);
				end
				bdm_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ms <= pwdata[15:0];
				end
				bdm_pkg::REG_REPEAT: begin
					cfg_q.repeat_interval_ms <= pwdata[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			bdm_pkg::REG_MODE:     prdata = {30'd0, cfg_q.mode};
			bdm_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_q.debounce_ms};
			bdm_pkg::REG_REPEAT:   prdata = {16'd0, cfg_q.repeat_interval_ms};
			default:               prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/bdm_core.sv =====
// ----------------------------------------------------------------------------
// bdm_core
// Debounce state and mode logic; one sample is applied per step_en.
// ----------------------------------------------------------------------------
`default_nettype none
`include "button_debounce_multimode_defines.svh"

module bdm_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bdm_pkg::cfg_t    cfg,
	input  wire logic             step_en,
	input  wire logic             level,
	input  wire bdm_pkg::tstamp_t now,
	output logic                  fire_d
);

	logic             last_raw_q;
	logic             stable_q;
	bdm_pkg::tstamp_t change_q;
	logic             out_flag_q;
	bdm_pkg::tstamp_t last_fire_q;

	bdm_pkg::tstamp_t change_d;
	bdm_pkg::tstamp_t last_fire_d;
	logic             settled;
	logic             stable_d;
	logic             press_edge;
	logic             rep_due;

	always_comb begin
		change_d    = (level != last_raw_q) ? now : change_q;
		// strict compare: a raw change is never taken on its own timestamp
		settled     = (now - change_d) > bdm_pkg::ms16_to_tstamp(cfg.debounce_ms);
		stable_d    = settled ? level : stable_q;
		press_edge  = settled && stable_q && !level;
		rep_due     = (now - last_fire_q) >=
			bdm_pkg::ms16_to_tstamp(cfg.repeat_interval_ms);
		fire_d      = out_flag_q;
		last_fire_d = last_fire_q;
		if (settled) begin
			case (cfg.mode)
				bdm_pkg::MODE_TOGGLE: fire_d = out_flag_q ^ press_edge;
				bdm_pkg::MODE_HOLD:   fire_d = !level;
				bdm_pkg::MODE_PULSE:  fire_d = press_edge;
				bdm_pkg::MODE_REPEAT: begin
					fire_d = !level && rep_due;
					if (!level && rep_due) begin
						last_fire_d = now;
					end
				end
				default: fire_d = out_flag_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= 1'b1;
			stable_q    <= 1'b1;
			change_q    <= '0;
			out_flag_q  <= 1'b0;
			last_fire_q <= '0;
		end else if (step_en) begin
			last_raw_q  <= level;
			stable_q    <= stable_d;
			change_q    <= change_d;
			out_flag_q  <= fire_d;
			last_fire_q <= last_fire_d;
		end
	end

	`BDM_ASSERT(a_stable_only_on_step, !step_en |=> $stable(stable_q))
	`BDM_ASSERT(a_hold_tracks_level,
		(step_en && settled && cfg.mode == bdm_pkg::MODE_HOLD) |=> (out_flag_q == !stable_q))
	`BDM_ASSERT(a_fire_time_with_flag, !$stable(last_fire_q) |-> out_flag_q)

endmodule

`default_nettype wire

// ===== rtl/button_debounce_multimode.sv =====
// ----------------------------------------------------------------------------
// button_debounce_multimode
// Button debouncer with toggle, hold, pulse and auto-repeat output modes.
// ----------------------------------------------------------------------------
// One sample transaction is taken every clock while sample_stall is low. Each one
// yields exactly one fire result, valid once the sample has passed the input
// register (loaded on acceptance) and the result register (loaded when the
// result side is empty or draining). The whole debounce update, two wrapping
// subtract-and-compare paths plus the mode select, is combinational between
// those registers, which is what sets the one-sample-per-clock rate. Backpressure
// on the result side stalls the sample side only when both registers are full.
// Registers (APB, byte address 4*i): mode at 0x0, debounce_ms at 0x4,
// repeat_interval_ms at 0x8; write them only while no transaction is in flight.
`default_nettype none
`include "button_debounce_multimode_defines.svh"

module button_debounce_multimode (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bdm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bdm_pkg::DATA_W-1:0] pwdata,
	output logic      [bdm_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	input  wire logic                       sample_valid,
	output logic                            sample_stall,
	input  wire logic                       level,
	input  wire logic [31:0]                now_ms,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic                            fire
);

	bdm_pkg::cfg_t    cfg;
	logic             valid_s1;
	logic             level_s1;
	bdm_pkg::tstamp_t now_s1;
	logic             valid_s2;
	logic             fire_s2;
	logic             fire_d;
	logic             advance;
	logic             take;

	bdm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// s1 moves on whenever the result register is empty or being drained
	assign advance      = !valid_s2 || !result_stall;
	assign sample_stall = valid_s1 && !advance;
	assign take         = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			level_s1 <= level;
			now_s1   <= bdm_pkg::to_tstamp(now_ms);
		end
	end

	bdm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (valid_s1 && advance),
		.level   (level_s1),
		.now     (now_s1),
		.fire_d  (fire_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			fire_s2 <= fire_d;
		end
	end

	assign result_valid = valid_s2;
	assign fire         = fire_s2;

	`BDM_ASSERT(a_s1_to_s2, (valid_s1 && advance) |=> valid_s2)
	`BDM_ASSERT(a_take_fills_s1, take |=> valid_s1)
	`BDM_NEVER(a_stall_needs_s1, sample_stall && !valid_s1)

endmodule

`default_nettype wire
